FILE: design/lavm_pkg.sv
// Package for the look-at view matrix core: payload types, constants and
// the rounding and saturation helpers shared by the pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lavm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    // Working width of the rounding and saturation helpers.
    localparam int PW            = 96;

    localparam logic [1:0] LAST_ROW = 2'd3;

    localparam logic signed [DATA_W-1:0] INT32_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] INT32_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [DATA_W-1:0] eye_x;
        logic signed [DATA_W-1:0] eye_y;
        logic signed [DATA_W-1:0] eye_z;
        logic signed [DATA_W-1:0] target_x;
        logic signed [DATA_W-1:0] target_y;
        logic signed [DATA_W-1:0] target_z;
        logic signed [DATA_W-1:0] up_x;
        logic signed [DATA_W-1:0] up_y;
        logic signed [DATA_W-1:0] up_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               row_index;
        logic signed [DATA_W-1:0] col0;
        logic signed [DATA_W-1:0] col1;
        logic signed [DATA_W-1:0] col2;
        logic signed [DATA_W-1:0] col3;
        logic                     last_row;
        logic                     degenerate;
    } out_item_t;

    // Arithmetic right shift of the magnitude with halves rounded away from zero.
    function automatic logic signed [PW-1:0] shr_round(input logic signed [PW-1:0] v,
                                                       input int s);
        logic [PW-1:0] m;
        logic [PW-1:0] r;
        m = v[PW-1] ? (~v + PW'(1)) : v;
        r = (m + (PW'(1) << (s - 1))) >> s;
        return v[PW-1] ? $signed(~r + PW'(1)) : $signed(r);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PW-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > PW'(INT32_MAX))
        begin
            r = INT32_MAX;
        end
        else if (v < PW'(INT32_MIN))
        begin
            r = INT32_MIN;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/lavm_if.sv
// Valid/ready channel interfaces for requests and matrix rows.
// Depends on lavm_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface lavm_in_if;
    logic               valid;
    logic               ready;
    lavm_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lavm_out_if;
    logic                valid;
    logic                ready;
    lavm_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/lavm_norm.sv
// Pipelined 3-vector normalizer: scaling, sum of squares, a digit-by-digit
// square root and three restoring dividers, one step per stage.
// Depends on lavm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lavm_norm #(
    parameter int VW        = 33,
    parameter int SB_W      = 1,
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [2:0][VW-1:0]          in_vec,
    input  logic [SB_W-1:0]             in_side,
    output logic                        out_valid,
    output logic [2:0][FRAC_BITS+1:0]   out_vec,
    output logic [SB_W-1:0]             out_side
);
    import lavm_pkg::*;

    localparam int PB = $clog2(VW);
    localparam int SW = 30;
    localparam int XW = 2 * SW + 2;
    localparam int QW = SW + 1;
    localparam int RW = QW + 2;
    localparam int QB = FRAC_BITS + 1;
    localparam int DW = QW + FRAC_BITS + 1;
    localparam int FW = FRAC_BITS + 2;
    localparam logic [PB-1:0] TOPB = PB'(SW - 1);

    typedef struct packed {
        logic [2:0][SW-1:0] a;
        logic [2:0]         neg;
        logic               zero;
        logic [SB_W-1:0]    side;
    } tag_t;

    // Stage 0: magnitudes.
    logic                v0_reg;
    logic [2:0][VW-1:0]  mag0_reg;
    logic [2:0]          neg0_reg;
    logic [SB_W-1:0]     side0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg0_reg[i] <= in_vec[i][VW-1];
                mag0_reg[i] <= in_vec[i][VW-1] ? (~in_vec[i] + VW'(1)) : in_vec[i];
            end
            side0_reg <= in_side;
        end
    end

    // Stage 1: position of the leading one of the largest magnitude.
    logic               v1_reg;
    logic [2:0][VW-1:0] mag1_reg;
    logic [2:0]         neg1_reg;
    logic [SB_W-1:0]    side1_reg;
    logic [PB-1:0]      pos1_reg;
    logic               zero1_reg;
    logic [VW-1:0]      or0;
    logic [PB-1:0]      pos0;

    always_comb
    begin
        or0  = mag0_reg[0] | mag0_reg[1] | mag0_reg[2];
        pos0 = '0;
        for (int b = 0; b < VW; b++)
        begin
            if (or0[b])
            begin
                pos0 = PB'(b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag0_reg;
            neg1_reg  <= neg0_reg;
            side1_reg <= side0_reg;
            pos1_reg  <= pos0;
            zero1_reg <= (or0 == '0);
        end
    end

    // Stage 2: bring the largest magnitude into [2^29, 2^30).
    logic v2_reg;
    tag_t t2_reg;
    tag_t t2_next;

    always_comb
    begin
        t2_next.neg  = neg1_reg;
        t2_next.zero = zero1_reg;
        t2_next.side = side1_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (pos1_reg >= TOPB)
            begin
                t2_next.a[i] = SW'(mag1_reg[i] >> (pos1_reg - TOPB));
            end
            else
            begin
                t2_next.a[i] = SW'(mag1_reg[i] << (TOPB - pos1_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg <= t2_next;
        end
    end

    // Stage 3: squares. Stage 4: sum of squares.
    logic                 v3_reg;
    tag_t                 t3_reg;
    logic [2:0][2*SW-1:0] sq3_reg;
    logic                 v4_reg;
    tag_t                 t4_reg;
    logic [XW-1:0]        x4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t3_reg <= t2_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq3_reg[i] <= t2_reg.a[i] * t2_reg.a[i];
            end
            t4_reg <= t3_reg;
            x4_reg <= XW'(sq3_reg[0]) + XW'(sq3_reg[1]) + XW'(sq3_reg[2]);
        end
    end

    // Square root, two radicand bits per stage.
    logic              sv_reg   [QW];
    tag_t              st_reg   [QW];
    logic [XW-1:0]     sx_reg   [QW];
    logic [RW-1:0]     srem_reg [QW];
    logic [QW-1:0]     sq_reg   [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_sqrt
        logic          v_in;
        tag_t          t_in;
        logic [XW-1:0] x_in;
        logic [RW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;

        if (k == 0)
        begin : g_first
            assign v_in   = v4_reg;
            assign t_in   = t4_reg;
            assign x_in   = x4_reg;
            assign rem_in = '0;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign v_in   = sv_reg[k-1];
            assign t_in   = st_reg[k-1];
            assign x_in   = sx_reg[k-1];
            assign rem_in = srem_reg[k-1];
            assign q_in   = sq_reg[k-1];
        end

        assign rem_sh = {rem_in[RW-3:0], x_in[XW-1-2*k -: 2]};
        assign trial  = {q_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= t_in;
                sx_reg[k] <= x_in;
                if (rem_sh >= trial)
                begin
                    srem_reg[k] <= rem_sh - trial;
                    sq_reg[k]   <= {q_in[QW-2:0], 1'b1};
                end
                else
                begin
                    srem_reg[k] <= rem_sh;
                    sq_reg[k]   <= {q_in[QW-2:0], 1'b0};
                end
            end
        end
    end

    // Divider setup: dividend is a * 2^FRAC_BITS plus half the norm.
    logic               dv0_reg;
    tag_t               dt0_reg;
    logic [QW-1:0]      dn0_reg;
    logic [2:0][DW-1:0] dr0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv0_reg <= 1'b0;
        end
        else if (en)
        begin
            dv0_reg <= sv_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dt0_reg <= st_reg[QW-1];
            dn0_reg <= sq_reg[QW-1];
            for (int i = 0; i < 3; i++)
            begin
                dr0_reg[i] <= (DW'(st_reg[QW-1].a[i]) << FRAC_BITS)
                            + DW'(sq_reg[QW-1] >> 1);
            end
        end
    end

    // Restoring division, one quotient bit per stage, three lanes.
    logic               dv_reg [QB];
    tag_t               dt_reg [QB];
    logic [QW-1:0]      dn_reg [QB];
    logic [2:0][DW-1:0] dr_reg [QB];
    logic [2:0][QB-1:0] dq_reg [QB];

    for (genvar s = 0; s < QB; s++)
    begin : g_div
        localparam int J = QB - 1 - s;
        logic               v_in;
        tag_t               t_in;
        logic [QW-1:0]      n_in;
        logic [2:0][DW-1:0] r_in;
        logic [2:0][QB-1:0] q_in;
        logic [DW-1:0]      dvs;

        if (s == 0)
        begin : g_first
            assign v_in = dv0_reg;
            assign t_in = dt0_reg;
            assign n_in = dn0_reg;
            assign r_in = dr0_reg;
            assign q_in = '0;
        end
        else
        begin : g_next
            assign v_in = dv_reg[s-1];
            assign t_in = dt_reg[s-1];
            assign n_in = dn_reg[s-1];
            assign r_in = dr_reg[s-1];
            assign q_in = dq_reg[s-1];
        end

        assign dvs = DW'(n_in) << J;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dt_reg[s] <= t_in;
                dn_reg[s] <= n_in;
                for (int i = 0; i < 3; i++)
                begin
                    if (r_in[i] >= dvs)
                    begin
                        dr_reg[s][i] <= r_in[i] - dvs;
                        dq_reg[s][i] <= {q_in[i][QB-2:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg[s][i] <= r_in[i];
                        dq_reg[s][i] <= {q_in[i][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid = dv_reg[QB-1];
        out_side  = dt_reg[QB-1].side;
        for (int i = 0; i < 3; i++)
        begin
            if (dt_reg[QB-1].zero)
            begin
                out_vec[i] = '0;
            end
            else if (dt_reg[QB-1].neg[i])
            begin
                out_vec[i] = ~FW'(dq_reg[QB-1][i]) + FW'(1);
            end
            else
            begin
                out_vec[i] = FW'(dq_reg[QB-1][i]);
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/look_at_view_matrix_core.sv
// Left-handed look-at view matrix core, top level.
// Depends on lavm_pkg, lavm_if and lavm_norm.
//
//   channel  role    payload                          per request
//   item     sink    eye, target, up (Q16.16)         one
//   rows     source  row_index, col0..col3, flags     four rows
//
// Throughput is set by the four rows that the output register hands out per
// request; the pipeline itself takes one a cycle whenever that register lets
// it advance. Most of the pipeline lies in the two normalizers (square root
// of 31 stages, divider of FRAC_BITS+1 stages).
// A stalled output register freezes every stage; nothing is dropped or repeated.
// Reset clears only the valid bits and the row counter; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module look_at_view_matrix_core #(
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lavm_in_if.sink     item,
    lavm_out_if.source  rows
);
    import lavm_pkg::*;

    localparam int FW = FRAC_BITS + 2;
    localparam int CW = DATA_W + FW + 1;
    localparam int UW = FRAC_BITS + 5;
    localparam int TW = FW + DATA_W + 2;
    localparam int TU = UW + DATA_W + 2;
    localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [2:0][DATA_W-1:0] eye;
        logic [2:0][DATA_W-1:0] up;
        logic                   degen;
    } side1_t;

    typedef struct packed {
        logic [2:0][DATA_W-1:0] eye;
        logic [2:0][FW-1:0]     fu;
        logic                   degen;
    } side2_t;

    logic adv;

    // Stage A: forward difference and the zero checks.
    logic                   a_valid_reg;
    side1_t                 a_side_reg;
    logic [2:0][DATA_W:0]   a_f_reg;
    logic [2:0][DATA_W:0]   a_f_next;
    side1_t                 a_side_next;

    always_comb
    begin
        a_side_next.eye = {item.data.eye_x, item.data.eye_y, item.data.eye_z};
        a_side_next.up  = {item.data.up_x, item.data.up_y, item.data.up_z};
        a_f_next[2] = (DATA_W+1)'(item.data.target_x) - (DATA_W+1)'(item.data.eye_x);
        a_f_next[1] = (DATA_W+1)'(item.data.target_y) - (DATA_W+1)'(item.data.eye_y);
        a_f_next[0] = (DATA_W+1)'(item.data.target_z) - (DATA_W+1)'(item.data.eye_z);
        a_side_next.degen = (a_f_next == '0) || (a_side_next.up == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg <= a_side_next;
            a_f_reg    <= a_f_next;
        end
    end

    assign item.ready = adv;

    // Forward axis. Packed index 2 holds x, 0 holds z.
    logic               n1_valid;
    logic [2:0][FW-1:0] n1_vec;
    side1_t             n1_side;

    lavm_norm #(
        .VW        (DATA_W + 1),
        .SB_W      ($bits(side1_t)),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .in_vec    (a_f_reg),
        .in_side   (a_side_reg),
        .out_valid (n1_valid),
        .out_vec   (n1_vec),
        .out_side  (n1_side)
    );

    // Cross product of up and forward, exact.
    logic signed [DATA_W-1:0] up_s [3];
    logic signed [FW-1:0]     fu_s [3];
    logic                     c1_valid_reg;
    side2_t                   c1_side_reg;
    logic signed [DATA_W+FW-1:0] c1_p_reg [6];
    logic                     c2_valid_reg;
    side2_t                   c2_side_reg;
    logic [2:0][CW-1:0]       c2_vec_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            up_s[i] = $signed(n1_side.up[2-i]);
            fu_s[i] = $signed(n1_vec[2-i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c1_valid_reg <= n1_valid;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_side_reg.eye   <= n1_side.eye;
            c1_side_reg.fu    <= n1_vec;
            c1_side_reg.degen <= n1_side.degen;
            c1_p_reg[0] <= up_s[1] * fu_s[2];
            c1_p_reg[1] <= up_s[2] * fu_s[1];
            c1_p_reg[2] <= up_s[2] * fu_s[0];
            c1_p_reg[3] <= up_s[0] * fu_s[2];
            c1_p_reg[4] <= up_s[0] * fu_s[1];
            c1_p_reg[5] <= up_s[1] * fu_s[0];
            c2_side_reg   <= c1_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                c2_vec_reg[2-i] <= CW'(c1_p_reg[2*i]) - CW'(c1_p_reg[2*i+1]);
            end
        end
    end

    // Right axis.
    logic               n2_valid;
    logic [2:0][FW-1:0] n2_vec;
    side2_t             n2_side;

    lavm_norm #(
        .VW        (CW),
        .SB_W      ($bits(side2_t)),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c2_valid_reg),
        .in_vec    (c2_vec_reg),
        .in_side   (c2_side_reg),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_side  (n2_side)
    );

    // U1: products for the true up axis and two of the dot products.
    logic signed [FW-1:0]     r_s   [3];
    logic signed [FW-1:0]     f2_s  [3];
    logic signed [DATA_W-1:0] eye_s [3];
    logic                     u1_valid_reg;
    side2_t                   u1_side_reg;
    logic [2:0][FW-1:0]       u1_r_reg;
    logic signed [2*FW-1:0]   u1_fr_reg [6];
    logic signed [FW+DATA_W-1:0] u1_re_reg [3];
    logic signed [FW+DATA_W-1:0] u1_fe_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_s[i]   = $signed(n2_vec[2-i]);
            f2_s[i]  = $signed(n2_side.fu[2-i]);
            eye_s[i] = $signed(n2_side.eye[2-i]);
        end
    end

    // U2: true up axis and forward/right dot sums.
    logic                     u2_valid_reg;
    side2_t                   u2_side_reg;
    logic [2:0][FW-1:0]       u2_r_reg;
    logic signed [UW-1:0]     u2_u_reg [3];
    logic signed [TW-1:0]     u2_tr_reg;
    logic signed [TW-1:0]     u2_tf_reg;
    // U3: up/eye products.
    logic                     u3_valid_reg;
    side2_t                   u3_side_reg;
    logic [2:0][FW-1:0]       u3_r_reg;
    logic signed [UW-1:0]     u3_u_reg [3];
    logic signed [TW-1:0]     u3_tr_reg;
    logic signed [TW-1:0]     u3_tf_reg;
    logic signed [UW+DATA_W-1:0] u3_ue_reg [3];
    // U4: finished matrix words.
    logic                     u4_valid_reg;
    logic                     u4_degen_reg;
    logic signed [DATA_W-1:0] u4_r_reg [3];
    logic signed [DATA_W-1:0] u4_u_reg [3];
    logic signed [DATA_W-1:0] u4_f_reg [3];
    logic signed [DATA_W-1:0] u4_t_reg [3];
    logic signed [TU-1:0]     tu_sum;

    assign tu_sum = TU'(u3_ue_reg[0]) + TU'(u3_ue_reg[1]) + TU'(u3_ue_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u1_valid_reg <= 1'b0;
            u2_valid_reg <= 1'b0;
            u3_valid_reg <= 1'b0;
            u4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            u1_valid_reg <= n2_valid;
            u2_valid_reg <= u1_valid_reg;
            u3_valid_reg <= u2_valid_reg;
            u4_valid_reg <= u3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u1_side_reg <= n2_side;
            u1_r_reg    <= n2_vec;
            u1_fr_reg[0] <= f2_s[1] * r_s[2];
            u1_fr_reg[1] <= f2_s[2] * r_s[1];
            u1_fr_reg[2] <= f2_s[2] * r_s[0];
            u1_fr_reg[3] <= f2_s[0] * r_s[2];
            u1_fr_reg[4] <= f2_s[0] * r_s[1];
            u1_fr_reg[5] <= f2_s[1] * r_s[0];
            for (int i = 0; i < 3; i++)
            begin
                u1_re_reg[i] <= r_s[i] * eye_s[i];
                u1_fe_reg[i] <= f2_s[i] * eye_s[i];
            end

            u2_side_reg <= u1_side_reg;
            u2_r_reg    <= u1_r_reg;
            for (int i = 0; i < 3; i++)
            begin
                u2_u_reg[i] <= UW'(shr_round(PW'(u1_fr_reg[2*i]) - PW'(u1_fr_reg[2*i+1]),
                                             FRAC_BITS));
            end
            u2_tr_reg <= TW'(u1_re_reg[0]) + TW'(u1_re_reg[1]) + TW'(u1_re_reg[2]);
            u2_tf_reg <= TW'(u1_fe_reg[0]) + TW'(u1_fe_reg[1]) + TW'(u1_fe_reg[2]);

            u3_side_reg <= u2_side_reg;
            u3_r_reg    <= u2_r_reg;
            u3_u_reg    <= u2_u_reg;
            u3_tr_reg   <= u2_tr_reg;
            u3_tf_reg   <= u2_tf_reg;
            for (int i = 0; i < 3; i++)
            begin
                u3_ue_reg[i] <= u2_u_reg[i] * $signed(u2_side_reg.eye[2-i]);
            end

            u4_degen_reg <= u3_side_reg.degen;
            for (int i = 0; i < 3; i++)
            begin
                if (u3_side_reg.degen)
                begin
                    u4_r_reg[i] <= '0;
                    u4_u_reg[i] <= '0;
                    u4_f_reg[i] <= '0;
                    u4_t_reg[i] <= '0;
                end
                else
                begin
                    u4_r_reg[i] <= DATA_W'($signed(u3_r_reg[2-i]));
                    u4_u_reg[i] <= DATA_W'(u3_u_reg[i]);
                    u4_f_reg[i] <= DATA_W'($signed(u3_side_reg.fu[2-i]));
                end
            end
            if (!u3_side_reg.degen)
            begin
                u4_t_reg[0] <= sat32(-shr_round(PW'(u3_tr_reg), FRAC_BITS));
                u4_t_reg[1] <= sat32(-shr_round(PW'(tu_sum), FRAC_BITS));
                u4_t_reg[2] <= sat32(-shr_round(PW'(u3_tf_reg), FRAC_BITS));
            end
        end
    end

    // Output register: hands out the four rows of one matrix.
    logic                     h_valid_reg;
    logic [1:0]               h_row_reg;
    logic                     h_degen_reg;
    logic signed [DATA_W-1:0] h_r_reg [3];
    logic signed [DATA_W-1:0] h_u_reg [3];
    logic signed [DATA_W-1:0] h_f_reg [3];
    logic signed [DATA_W-1:0] h_t_reg [3];

    assign adv = !h_valid_reg || (rows.ready && h_row_reg == LAST_ROW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            h_row_reg   <= '0;
        end
        else if (adv)
        begin
            h_valid_reg <= u4_valid_reg;
            h_row_reg   <= '0;
        end
        else if (rows.ready)
        begin
            h_row_reg <= h_row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_degen_reg <= u4_degen_reg;
            h_r_reg     <= u4_r_reg;
            h_u_reg     <= u4_u_reg;
            h_f_reg     <= u4_f_reg;
            h_t_reg     <= u4_t_reg;
        end
    end

    always_comb
    begin
        rows.valid           = h_valid_reg;
        rows.data.row_index  = h_row_reg;
        rows.data.last_row   = (h_row_reg == LAST_ROW);
        rows.data.degenerate = h_degen_reg;
        case (h_row_reg)
            2'd0:
            begin
                rows.data.col0 = h_r_reg[0];
                rows.data.col1 = h_u_reg[0];
                rows.data.col2 = h_f_reg[0];
                rows.data.col3 = '0;
            end
            2'd1:
            begin
                rows.data.col0 = h_r_reg[1];
                rows.data.col1 = h_u_reg[1];
                rows.data.col2 = h_f_reg[1];
                rows.data.col3 = '0;
            end
            2'd2:
            begin
                rows.data.col0 = h_r_reg[2];
                rows.data.col1 = h_u_reg[2];
                rows.data.col2 = h_f_reg[2];
                rows.data.col3 = '0;
            end
            default:
            begin
                rows.data.col0 = h_t_reg[0];
                rows.data.col1 = h_t_reg[1];
                rows.data.col2 = h_t_reg[2];
                rows.data.col3 = h_degen_reg ? '0 : $signed(ONE_Q);
            end
        endcase
    end

    // A taken row that is not the last is followed by the next row of the same matrix.
    a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid && rows.ready && !rows.data.last_row |=>
            rows.valid && rows.data.row_index == 2'($past(rows.data.row_index) + 2'd1))
        else $error("row sequence broken");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid && rows.data.degenerate |->
            rows.data.col0 == '0 && rows.data.col1 == '0 && rows.data.col3 == '0)
        else $error("degenerate matrix not cleared");

    a_w_one: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid && rows.data.last_row && !rows.data.degenerate |->
            rows.data.col3 == $signed(ONE_Q))
        else $error("translation row w is not one");

    a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready && h_valid_reg |-> h_row_reg == LAST_ROW)
        else $error("request accepted while a matrix is half sent");

endmodule

`default_nettype wire
